>>> src/sdu_pkg.sv
// ----------------------------------------------------------------------------
// Signal dispatch unit package
// Operation, disposition and status codes, controller commands, the status
// record shared by the controller and the datapath, and the result record.
// ----------------------------------------------------------------------------
package sdu_pkg;

    localparam int SIG_W      = 5;
    localparam int MASK_W     = 32;
    localparam int ADDR_W     = 32;
    localparam int KIND_W     = 3;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 112;

    localparam logic [OP_W-1:0] OP_POST   = 3'd0;
    localparam logic [OP_W-1:0] OP_SWAP   = 3'd1;
    localparam logic [OP_W-1:0] OP_SET    = 3'd2;
    localparam logic [OP_W-1:0] OP_CHECK  = 3'd3;
    localparam logic [OP_W-1:0] OP_RETURN = 3'd4;

    localparam logic [KIND_W-1:0] KIND_DEFAULT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_IGNORE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_KILL    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STOP    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CONT    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_USER    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_YIELD  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TERM   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ENTER  = 3'd4;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_POST,
        CMD_SWAP,
        CMD_SET_RD,
        CMD_SET_WR,
        CMD_REJECT,
        CMD_YIELD,
        CMD_RETURN,
        CMD_SCAN_START,
        CMD_SCAN_NEXT,
        CMD_SCAN_RD,
        CMD_EVAL,
        CMD_OUT_LOAD
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            set_ok;
        logic            must_yield;
        logic            eligible;
        logic            last;
        logic            eval_end;
        logic            out_free;
    } t_stat;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SIG_W-1:0]    chosen;
        logic [ADDR_W-1:0]   entry;
        logic [MASK_W-1:0]   old_mask;
        logic [KIND_W-1:0]   old_kind;
        logic [ADDR_W-1:0]   old_address;
    } t_result;

endpackage

>>> src/sdu_ctrl.sv
// ----------------------------------------------------------------------------
// Signal dispatch unit controller
// One-hot state machine that sequences decode, action table access, the
// signal scan and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module sdu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    output logic           o_s_ready,
    input  sdu_pkg::t_stat i_stat,
    output sdu_pkg::t_cmd  o_cmd
);
    import sdu_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SETWR  = 6'b000100,
        S_SCAN   = 6'b001000,
        S_EVAL   = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd   = CMD_LATCH;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FIN;
                unique case (i_stat.op)
                    OP_POST:   o_cmd = CMD_POST;
                    OP_SWAP:   o_cmd = CMD_SWAP;
                    OP_SET: begin
                        if (i_stat.set_ok) begin
                            o_cmd   = CMD_SET_RD;
                            n_state = S_SETWR;
                        end else begin
                            o_cmd = CMD_REJECT;
                        end
                    end
                    OP_CHECK: begin
                        if (i_stat.must_yield) begin
                            o_cmd = CMD_YIELD;
                        end else begin
                            o_cmd   = CMD_SCAN_START;
                            n_state = S_SCAN;
                        end
                    end
                    OP_RETURN: o_cmd = CMD_RETURN;
                    default:   o_cmd = CMD_REJECT;
                endcase
            end
            S_SETWR: begin
                o_cmd   = CMD_SET_WR;
                n_state = S_FIN;
            end
            S_SCAN: begin
                // Skip signals not pending, or blocked and not kill or stop.
                priority if (i_stat.eligible) begin
                    o_cmd   = CMD_SCAN_RD;
                    n_state = S_EVAL;
                end else if (i_stat.last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd = CMD_SCAN_NEXT;
                end
            end
            S_EVAL: begin
                o_cmd = CMD_EVAL;
                if (i_stat.eval_end || i_stat.last) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd   = CMD_OUT_LOAD;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !i_stat.out_free) |=> (r_state == S_FIN))
        else $error("finished item left FIN while the output register was full");

    a_eval_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> $past(r_state == S_SCAN))
        else $error("EVAL entered without a table read from SCAN");

    a_setwr_after_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETWR) |-> $past(r_state == S_DECODE))
        else $error("action write without a preceding decode");

endmodule

>>> src/sdu_dp.sv
// ----------------------------------------------------------------------------
// Signal dispatch unit datapath
// Signal state registers, the per-signal action tables, the scan index,
// the result record and the output register, all driven by controller
// commands.
// ----------------------------------------------------------------------------
module sdu_dp #(
    parameter int NUM_SIGNALS = 32,
    parameter int KILL_SIGNAL = 9,
    parameter int STOP_SIGNAL = 17,
    parameter int CONT_SIGNAL = 19
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sdu_pkg::t_cmd                    i_cmd,
    input  logic [sdu_pkg::IN_DATA_W-1:0]    i_s_data,
    input  logic [sdu_pkg::OP_W-1:0]         i_s_user,
    output sdu_pkg::t_stat                   o_stat,
    output logic                             o_m_valid,
    input  logic                             i_m_ready,
    output logic [sdu_pkg::OUT_DATA_W-1:0]   o_m_data,
    output logic [sdu_pkg::STATUS_W-1:0]     o_m_user
);
    import sdu_pkg::*;

    localparam int              AW       = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;
    localparam logic [SIG_W:0]  NUM_EXT  = (SIG_W + 1)'(NUM_SIGNALS);
    localparam logic [SIG_W-1:0] LAST_IDX = SIG_W'(NUM_SIGNALS - 1);
    localparam logic [SIG_W-1:0] KILL_IDX = SIG_W'(KILL_SIGNAL);
    localparam logic [SIG_W-1:0] STOP_IDX = SIG_W'(STOP_SIGNAL);
    localparam logic [SIG_W-1:0] CONT_IDX = SIG_W'(CONT_SIGNAL);

    // Latched input item.
    logic [OP_W-1:0]   r_op;
    logic [SIG_W-1:0]  r_sig;
    logic [MASK_W-1:0] r_nmask;
    logic [KIND_W-1:0] r_kind;
    logic [ADDR_W-1:0] r_haddr;
    logic [MASK_W-1:0] r_hmask;

    // Signal state.
    logic [MASK_W-1:0] r_pending, n_pending;
    logic [MASK_W-1:0] r_blocked, n_blocked;
    logic [MASK_W-1:0] r_saved,   n_saved;
    logic              r_stopped, n_stopped;
    logic              r_uha,     n_uha;
    logic [SIG_W-1:0]  r_idx,     n_idx;

    t_result           r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_result           r_out_res, n_out_res;
    logic              r_out_stopped, n_out_stopped;

    // Action tables with one valid bit per entry; an unwritten entry reads
    // as the default action with zero address and mask.
    logic [KIND_W-1:0] mem_kind [NUM_SIGNALS];
    logic [ADDR_W-1:0] mem_addr [NUM_SIGNALS];
    logic [MASK_W-1:0] mem_mask [NUM_SIGNALS];
    logic [NUM_SIGNALS-1:0] r_ent_valid;
    logic [KIND_W-1:0] r_rd_kind;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [MASK_W-1:0] r_rd_mask;
    logic [AW-1:0]     rd_a;
    logic [AW-1:0]     wr_a;

    logic              in_range;
    logic              unmaskable;
    logic [KIND_W-1:0] eff_kind;
    logic              is_user;

    assign in_range   = ({1'b0, r_sig} < NUM_EXT);
    assign unmaskable = (r_idx == KILL_IDX) || (r_idx == STOP_IDX);
    assign rd_a       = (i_cmd == CMD_SET_RD) ? r_sig[AW-1:0] : r_idx[AW-1:0];
    assign wr_a       = r_sig[AW-1:0];

    // The default action resolves per signal.
    always_comb begin
        eff_kind = r_rd_kind;
        if (r_rd_kind == KIND_DEFAULT) begin
            priority if (r_idx == KILL_IDX) begin
                eff_kind = KIND_KILL;
            end else if (r_idx == STOP_IDX) begin
                eff_kind = KIND_STOP;
            end else if (r_idx == CONT_IDX) begin
                eff_kind = KIND_CONT;
            end else begin
                eff_kind = KIND_KILL;
            end
        end
    end

    assign is_user = (eff_kind != KIND_IGNORE) && (eff_kind != KIND_KILL) &&
                     (eff_kind != KIND_STOP) && (eff_kind != KIND_CONT);

    assign o_stat.op         = r_op;
    assign o_stat.set_ok     = in_range && (r_sig != KILL_IDX) && (r_sig != STOP_IDX) &&
                               (r_kind <= KIND_USER);
    assign o_stat.must_yield = r_stopped && !(r_pending[CONT_IDX] && !r_pending[KILL_IDX]);
    assign o_stat.eligible   = r_pending[r_idx] && (!r_blocked[r_idx] || unmaskable);
    assign o_stat.last       = (r_idx == LAST_IDX);
    assign o_stat.eval_end   = (eff_kind == KIND_KILL) || (is_user && !r_uha);
    assign o_stat.out_free   = !r_out_valid || i_m_ready;

    always_comb begin
        n_pending     = r_pending;
        n_blocked     = r_blocked;
        n_saved       = r_saved;
        n_stopped     = r_stopped;
        n_uha         = r_uha;
        n_idx         = r_idx;
        n_res         = r_res;
        n_out_valid   = r_out_valid && !i_m_ready;
        n_out_res     = r_out_res;
        n_out_stopped = r_out_stopped;
        unique case (i_cmd)
            CMD_LATCH: n_res = '0;
            CMD_POST: begin
                if (in_range) begin
                    n_pending[r_sig] = 1'b1;
                end else begin
                    n_res.status = ST_REJECT;
                end
            end
            CMD_SWAP: begin
                n_res.old_mask = r_blocked;
                n_blocked      = r_nmask;
            end
            CMD_SET_WR: begin
                n_res.old_kind    = r_rd_kind;
                n_res.old_address = r_rd_addr;
                n_res.old_mask    = (r_rd_kind == KIND_USER) ? r_rd_mask : r_blocked;
            end
            CMD_REJECT: n_res.status = ST_REJECT;
            CMD_YIELD:  n_res.status = ST_YIELD;
            CMD_RETURN: begin
                n_blocked = r_saved;
                n_uha     = 1'b0;
            end
            CMD_SCAN_START: n_idx = '0;
            CMD_SCAN_NEXT:  n_idx = r_idx + SIG_W'(1);
            CMD_EVAL: begin
                if (r_idx != LAST_IDX) begin
                    n_idx = r_idx + SIG_W'(1);
                end
                priority if (eff_kind == KIND_IGNORE) begin
                    n_pending[r_idx] = 1'b0;
                end else if (eff_kind == KIND_KILL) begin
                    n_pending[r_idx] = 1'b0;
                    n_res.status     = ST_TERM;
                    n_res.chosen     = r_idx;
                end else if (eff_kind == KIND_STOP) begin
                    n_pending[r_idx] = 1'b0;
                    n_stopped        = 1'b1;
                end else if (eff_kind == KIND_CONT) begin
                    n_pending[r_idx] = 1'b0;
                    n_stopped        = 1'b0;
                end else if (!r_uha) begin
                    n_saved          = r_blocked;
                    n_blocked        = r_rd_mask;
                    n_uha            = 1'b1;
                    n_pending[r_idx] = 1'b0;
                    n_res.status     = ST_ENTER;
                    n_res.chosen     = r_idx;
                    n_res.entry      = r_rd_addr;
                end
            end
            CMD_OUT_LOAD: begin
                n_out_valid   = 1'b1;
                n_out_res     = r_res;
                n_out_stopped = r_stopped;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_blocked   <= '0;
            r_saved     <= '0;
            r_stopped   <= 1'b0;
            r_uha       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pending   <= n_pending;
            r_blocked   <= n_blocked;
            r_saved     <= n_saved;
            r_stopped   <= n_stopped;
            r_uha       <= n_uha;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res         <= n_res;
        r_out_res     <= n_out_res;
        r_out_stopped <= n_out_stopped;
        if (i_cmd == CMD_LATCH) begin
            r_op    <= i_s_user;
            r_sig   <= i_s_data[4:0];
            r_nmask <= i_s_data[36:5];
            r_kind  <= i_s_data[39:37];
            r_haddr <= i_s_data[71:40];
            r_hmask <= i_s_data[103:72];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= '0;
        end else if (i_cmd == CMD_SET_WR) begin
            r_ent_valid[wr_a] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_SET_WR) begin
            mem_kind[wr_a] <= r_kind;
            mem_addr[wr_a] <= (r_kind == KIND_USER) ? r_haddr : '0;
            mem_mask[wr_a] <= r_hmask;
        end
        r_rd_kind <= r_ent_valid[rd_a] ? mem_kind[rd_a] : KIND_DEFAULT;
        r_rd_addr <= r_ent_valid[rd_a] ? mem_addr[rd_a] : '0;
        r_rd_mask <= r_ent_valid[rd_a] ? mem_mask[rd_a] : '0;
    end

    assign o_m_valid = r_out_valid;
    assign o_m_user  = r_out_res.status;
    assign o_m_data  = {7'b0, r_out_stopped, r_out_res.old_address, r_out_res.old_kind,
                        r_out_res.old_mask, r_out_res.entry, r_out_res.chosen};

    a_uha_on_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_uha) |-> (r_res.status == ST_ENTER))
        else $error("handler marked active without a handler entry result");

    a_stopped_by_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_stopped)) |-> $past(i_cmd == CMD_EVAL))
        else $error("stopped flag changed outside a scan step");

    a_blocked_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_blocked)) |->
        $past(i_cmd == CMD_SWAP || i_cmd == CMD_RETURN || i_cmd == CMD_EVAL))
        else $error("blocked mask changed by an unexpected command");

endmodule

>>> src/signal_dispatch_unit_top.sv
// ----------------------------------------------------------------------------
// Signal dispatch unit
// Pending, blocked and saved signal masks, stop and handler state, and a
// per-signal action table for one process context.
//
//   Channel  Direction  Payload
//   s_axis   in         tuser: operation; tdata: signal_number, new_mask,
//                       handler_kind, handler_address, handler_mask
//   m_axis   out        tuser: status; tdata: chosen_signal, entry_address,
//                       old_mask, old_kind, old_address, stopped
//
// Post, swap, handler return and rejected items pass through decode and then
// finish; set action adds a write step after the registered table read.
// A check scans one signal per cycle, plus an evaluation step for each pending
// signal that is not blocked (kill and stop count even when blocked), whether
// or not it acts on it; a kill or a handler entry ends the scan early.
// A new item is accepted while the previous result waits in the output
// register; a finished item holds until that register is free.
// Reset is synchronous and active low and clears all signal state and the
// table valid bits.
// ----------------------------------------------------------------------------
module signal_dispatch_unit_top #(
    parameter int NUM_SIGNALS = 32,
    parameter int KILL_SIGNAL = 9,
    parameter int STOP_SIGNAL = 17,
    parameter int CONT_SIGNAL = 19
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // signal_number[4:0], new_mask[36:5], handler_kind[39:37],
    // handler_address[71:40], handler_mask[103:72]
    input  logic [sdu_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation[2:0]
    input  logic [sdu_pkg::OP_W-1:0]       s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // chosen_signal[4:0], entry_address[36:5], old_mask[68:37],
    // old_kind[71:69], old_address[103:72], stopped[104], zeros above
    output logic [sdu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [sdu_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import sdu_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sdu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    sdu_dp #(
        .NUM_SIGNALS (NUM_SIGNALS),
        .KILL_SIGNAL (KILL_SIGNAL),
        .STOP_SIGNAL (STOP_SIGNAL),
        .CONT_SIGNAL (CONT_SIGNAL)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_s_data  (s_axis_tdata),
        .i_s_user  (s_axis_tuser),
        .o_stat    (stat),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_data  (m_axis_tdata),
        .o_m_user  (m_axis_tuser)
    );

endmodule
